// File: hw/rtl/lr_pkg.sv
// Shared types and constants of the line rasterizer: coordinate widths,
// command and pixel payloads, and the job record passed from front to back.
// No dependencies.
`timescale 1ns / 1ps

package lr_pkg;

    // coordinate width; every coordinate field and span follows from it
    localparam int COORD_BITS = 11;
    localparam int SPAN_BITS  = COORD_BITS + 1;   // signed spans
    localparam int ERR_BITS   = COORD_BITS + 3;   // Bresenham error, signed
    localparam int COLOR_BITS = 32;

    // job queue depth, a power of two
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_BITS = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } t_op;

    typedef logic [COORD_BITS-1:0] t_coord;

    // input request
    typedef struct packed {
        t_op                   opcode;
        t_coord                x_start;
        t_coord                y_start;
        t_coord                x_end;
        t_coord                y_end;
        logic [COLOR_BITS-1:0] line_color;
    } t_cmd;

    // result request
    typedef struct packed {
        t_coord                pixel_x;
        t_coord                pixel_y;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  last_pixel;
    } t_pix;

    // classified job with the line setup already worked out
    typedef struct packed {
        t_op                          opcode;
        t_coord                       x0;
        t_coord                       y0;
        t_coord                       x1;
        t_coord                       y1;
        logic [COORD_BITS-1:0]        span_x;
        logic signed [SPAN_BITS-1:0]  neg_span_y;
        logic                         step_left;
        logic                         step_up;
        logic [COLOR_BITS-1:0]        color;
    } t_job;

    // handshake between queue and its neighbours
    typedef struct packed {
        logic valid;
        logic ready;
    } t_hs;

endpackage

// File: hw/rtl/lr_if.sv
// Valid/ready channel interfaces for the line rasterizer requests.
// Depends on lr_pkg.
`timescale 1ns / 1ps

interface lr_cmd_if;
    import lr_pkg::*;

    logic valid;
    logic ready;
    t_cmd payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lr_pix_if;
    import lr_pkg::*;

    logic valid;
    logic ready;
    t_pix payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/lr_front.sv
// Front end: accepts command requests, classifies them and works out the
// line setup (spans, step directions) for a start. Depends on lr_pkg.
`timescale 1ns / 1ps

module lr_front (
    input  lr_pkg::t_cmd i_cmd,
    output lr_pkg::t_job o_job
);
    import lr_pkg::*;

    logic                  x_fwd;
    logic                  y_fwd;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;

    // absolute spans and step directions
    always_comb begin
        x_fwd = i_cmd.x_start < i_cmd.x_end;
        y_fwd = i_cmd.y_start < i_cmd.y_end;
        dx    = x_fwd ? (i_cmd.x_end - i_cmd.x_start) : (i_cmd.x_start - i_cmd.x_end);
        dy    = y_fwd ? (i_cmd.y_end - i_cmd.y_start) : (i_cmd.y_start - i_cmd.y_end);
    end

    // pack the job record
    always_comb begin
        o_job.opcode     = i_cmd.opcode;
        o_job.x0         = i_cmd.x_start;
        o_job.y0         = i_cmd.y_start;
        o_job.x1         = i_cmd.x_end;
        o_job.y1         = i_cmd.y_end;
        o_job.span_x     = dx;
        o_job.neg_span_y = -$signed({1'b0, dy});
        o_job.step_left  = ~x_fwd;
        o_job.step_up    = ~y_fwd;
        o_job.color      = i_cmd.line_color;
    end

endmodule

// File: hw/rtl/lr_queue.sv
// Short job queue decoupling the front end from the stepping back end.
// Depends on lr_pkg.
`timescale 1ns / 1ps

module lr_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  lr_pkg::t_job i_job,
    input  logic         i_push,
    output logic         o_full,
    output lr_pkg::t_job o_job,
    output lr_pkg::t_hs  o_pop_hs,
    input  logic         i_pop
);
    import lr_pkg::*;

    t_job                  r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr_ptr;
    logic [Q_PTR_BITS-1:0] r_rd_ptr;
    logic [Q_PTR_BITS:0]   r_count;
    logic [Q_PTR_BITS:0]   n_count;

    assign o_full         = (r_count == (Q_PTR_BITS+1)'(Q_DEPTH));
    assign o_job          = r_mem[r_rd_ptr];
    assign o_pop_hs.valid = (r_count != '0);
    assign o_pop_hs.ready = i_pop;

    // track occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !(i_pop && o_pop_hs.valid)) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop && o_pop_hs.valid) begin
            n_count = r_count - 1'b1;
        end
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop && o_pop_hs.valid) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// File: hw/rtl/lr_back.sv
// Back end: holds the Bresenham state, runs one job a cycle unless the output
// stalls, and drives the registered pixel output. Depends on lr_pkg and lr_if.
`timescale 1ns / 1ps

module lr_back (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  lr_pkg::t_job i_job,
    input  lr_pkg::t_hs  i_job_hs,
    output logic         o_pop,
    lr_pix_if.source     o_pix
);
    import lr_pkg::*;

    t_coord                        r_cur_col,  n_cur_col;
    t_coord                        r_cur_row,  n_cur_row;
    t_coord                        r_end_col,  n_end_col;
    t_coord                        r_end_row,  n_end_row;
    logic signed [SPAN_BITS-1:0]   r_span_x,   n_span_x;
    logic signed [SPAN_BITS-1:0]   r_neg_span_y, n_neg_span_y;
    logic                          r_step_left, n_step_left;
    logic                          r_step_up,   n_step_up;
    logic signed [ERR_BITS-1:0]    r_err,       n_err;
    logic [COLOR_BITS-1:0]         r_color,     n_color;
    logic                          r_active,    n_active;
    logic                          r_out_valid, n_out_valid;
    t_pix                          r_out,       n_out;

    logic                          take;
    logic                          emit;
    logic signed [ERR_BITS:0]      twice;
    logic                          move_x;
    logic                          move_y;
    logic signed [SPAN_BITS-1:0]   start_span_x;
    logic                          last;

    // take a job whenever the output register has room
    assign o_pop = ~r_out_valid | o_pix.ready;
    assign take  = i_job_hs.valid & i_job_hs.ready;

    assign o_pix.valid   = r_out_valid;
    assign o_pix.payload = r_out;

    always_comb begin
        start_span_x = $signed({1'b0, i_job.span_x});
        twice        = {r_err, 1'b0};
        move_x       = twice >= ERR_BITS'(r_neg_span_y);
        move_y       = twice <= ERR_BITS'(r_span_x);

        n_cur_col    = r_cur_col;
        n_cur_row    = r_cur_row;
        n_end_col    = r_end_col;
        n_end_row    = r_end_row;
        n_span_x     = r_span_x;
        n_neg_span_y = r_neg_span_y;
        n_step_left  = r_step_left;
        n_step_up    = r_step_up;
        n_err        = r_err;
        n_color      = r_color;
        emit         = 1'b0;

        if (take) begin
            unique case (i_job.opcode)
                OP_START: begin
                    // load a new line, dropping any line in progress
                    n_cur_col    = i_job.x0;
                    n_cur_row    = i_job.y0;
                    n_end_col    = i_job.x1;
                    n_end_row    = i_job.y1;
                    n_span_x     = start_span_x;
                    n_neg_span_y = i_job.neg_span_y;
                    n_step_left  = i_job.step_left;
                    n_step_up    = i_job.step_up;
                    n_err        = ERR_BITS'(start_span_x) + ERR_BITS'(i_job.neg_span_y);
                    n_color      = i_job.color;
                    emit         = 1'b1;
                end
                OP_ADVANCE: begin
                    // one Bresenham step; drop the request while idle
                    if (r_active) begin
                        n_err = r_err
                              + (move_x ? ERR_BITS'(r_neg_span_y) : '0)
                              + (move_y ? ERR_BITS'(r_span_x) : '0);
                        if (move_x) begin
                            n_cur_col = r_step_left ? r_cur_col - 1'b1 : r_cur_col + 1'b1;
                        end
                        if (move_y) begin
                            n_cur_row = r_step_up ? r_cur_row - 1'b1 : r_cur_row + 1'b1;
                        end
                        emit = 1'b1;
                    end
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end

        last     = (n_cur_col == n_end_col) && (n_cur_row == n_end_row);
        n_active = emit ? ~last : r_active;

        // output register
        n_out_valid = emit | (r_out_valid & ~o_pix.ready);
        n_out       = r_out;
        if (emit) begin
            n_out.pixel_x     = n_cur_col;
            n_out.pixel_y     = n_cur_row;
            n_out.pixel_color = n_color;
            n_out.last_pixel  = last;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    // line state and output payload
    always_ff @(posedge i_clk) begin
        r_cur_col    <= n_cur_col;
        r_cur_row    <= n_cur_row;
        r_end_col    <= n_end_col;
        r_end_row    <= n_end_row;
        r_span_x     <= n_span_x;
        r_neg_span_y <= n_neg_span_y;
        r_step_left  <= n_step_left;
        r_step_up    <= n_step_up;
        r_err        <= n_err;
        r_color      <= n_color;
        r_out        <= n_out;
    end

endmodule

// File: hw/rtl/line_rasterizer_core.sv
// Bresenham line rasterizer: a start request loads a line and emits its first
// pixel, and each advance request emits the next pixel, flagging the endpoint as
// last; an advance while no line is active gives no pixel. Every request goes
// through the back end's single add-compare step, so one pixel per clock is
// sustained while the pixel sink keeps up. Requests wait in a two-entry job
// queue between classification and stepping, which lets the input keep flowing
// for two requests while the output stalls; pixels leave from a register.
// Depends on lr_pkg, lr_if, lr_front, lr_queue and lr_back.
`timescale 1ns / 1ps

module line_rasterizer_core (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lr_cmd_if.sink   i_cmd,
    lr_pix_if.source o_pix
);
    import lr_pkg::*;

    t_job front_job;
    t_job queue_job;
    t_hs  queue_hs;
    logic queue_full;
    logic push;
    logic pop;

    // accept requests while the queue has room
    assign i_cmd.ready = ~queue_full;
    assign push        = i_cmd.valid & ~queue_full;

    lr_front u_front (
        .i_cmd (i_cmd.payload),
        .o_job (front_job)
    );

    lr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (front_job),
        .i_push   (push),
        .o_full   (queue_full),
        .o_job    (queue_job),
        .o_pop_hs (queue_hs),
        .i_pop    (pop)
    );

    lr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (queue_job),
        .i_job_hs (queue_hs),
        .o_pop    (pop),
        .o_pix    (o_pix)
    );

endmodule
